[hdl/lsfe_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// lsfe_pkg - shared types and helpers for the LSB frame extractor
// Configuration register indexes, result status codes, the configuration
// bundle and the result record passed between the extractor's modules.
// ---------------------------------------------------------------------------
package lsfe_pkg;

  localparam int unsigned MAGIC_MAX_BYTES = 8;
  localparam int unsigned HDR_W           = 10;
  localparam int unsigned MAGIC_W         = 64;
  localparam int unsigned MLEN_W          = 4;
  localparam int unsigned EXT_W           = 32;
  localparam int unsigned ELEN_W          = 3;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 64;
  localparam int unsigned SIZE_W          = 32;
  localparam int unsigned BCNT_W          = 6;
  localparam int unsigned TGT_W           = 7;

  localparam logic [HDR_W-1:0]   HDR_SKIP_RST  = 10'd54;
  localparam logic [MAGIC_W-1:0] MAGIC_RST     = 64'd9002;
  localparam logic [MLEN_W-1:0]  MLEN_RST      = 4'd2;
  localparam logic [EXT_W-1:0]   EXT_RST       = 32'h2E74_7874;
  localparam logic [ELEN_W-1:0]  ELEN_RST      = 3'd4;
  localparam logic [TGT_W-1:0]   WORD_BITS     = 7'd32;
  localparam logic [TGT_W-1:0]   BYTE_BITS     = 7'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_SKIP = 3'd0,
    CFG_MAGIC_VALUE = 3'd1,
    CFG_MAGIC_LEN   = 3'd2,
    CFG_EXT_VALUE   = 3'd3,
    CFG_EXT_LEN     = 3'd4
  } lsfe_cfg_idx_t;

  typedef enum logic [1:0] {
    ST_DATA       = 2'd0,
    ST_MAGIC_ERR  = 2'd1,
    ST_EXTLEN_ERR = 2'd2,
    ST_EXT_ERR    = 2'd3
  } lsfe_status_t;

  typedef struct packed {
    logic [HDR_W-1:0]   header_skip;
    logic [MAGIC_W-1:0] magic_value;
    logic [MLEN_W-1:0]  magic_length;
    logic [EXT_W-1:0]   extension_value;
    logic [ELEN_W-1:0]  extension_length;
  } lsfe_cfg_t;

  typedef struct packed {
    logic         vld;
    logic [7:0]   data;
    lsfe_status_t status;
    logic         last;
  } lsfe_res_t;

  // Clamp magic length to 1..MAGIC_MAX_BYTES
  function automatic logic [MLEN_W-1:0] magic_bytes(input logic [MLEN_W-1:0] len);
    logic [MLEN_W-1:0] n;
    n = len;
    if (n == '0) n = MLEN_W'(1);
    if (n > MLEN_W'(MAGIC_MAX_BYTES)) n = MLEN_W'(MAGIC_MAX_BYTES);
    return n;
  endfunction

  // Clamp extension length to 1..4
  function automatic logic [ELEN_W-1:0] ext_bytes(input logic [ELEN_W-1:0] len);
    logic [ELEN_W-1:0] n;
    n = len;
    if (n == '0) n = ELEN_W'(1);
    if (n > ELEN_W'(4)) n = ELEN_W'(4);
    return n;
  endfunction

endpackage : lsfe_pkg
`default_nettype wire

[hdl/lsfe_in_stage.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// lsfe_in_stage - input register
// Holds one accepted image byte (its data bit and image start flag) until
// the parser takes it; refills in the same cycle it is taken.
// ---------------------------------------------------------------------------
module lsfe_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_pixel_byte,
  input  wire logic       in_first_of_image,
  input  wire logic       out_free,
  output logic            take,
  output logic            stg_bit,
  output logic            stg_first
);
  import lsfe_pkg::*;

  logic vld_r, vld_nxt;
  logic bit_r, first_r;

  assign take     = vld_r & out_free;
  assign in_ready = ~vld_r | take;
  assign vld_nxt  = (in_valid & in_ready) | (vld_r & ~take);
  assign stg_bit   = bit_r;
  assign stg_first = first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      bit_r   <= in_pixel_byte[0];
      first_r <= in_first_of_image;
    end
  end

endmodule : lsfe_in_stage
`default_nettype wire

[hdl/lsfe_parser.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// lsfe_parser - hidden stream field parser
// Past the header, shifts one hidden bit per byte into the field accumulator, checks each
// completed field and produces at most one result per byte.
// ---------------------------------------------------------------------------
module lsfe_parser (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                fire,
  input  wire logic                stg_bit,
  input  wire logic                stg_first,
  input  wire lsfe_pkg::lsfe_cfg_t cfg,
  output lsfe_pkg::lsfe_res_t      res
);
  import lsfe_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_MAGIC   = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_EXT     = 3'd3,
    PH_SIZE    = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_IDLE    = 3'd6
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [HDR_W-1:0]    hcnt_r, hcnt_nxt;
  logic [BCNT_W-1:0]   bcnt_r, bcnt_nxt;
  logic [MAGIC_W-1:0]  acc_r, acc_nxt;
  logic [SIZE_W-1:0]   rem_r, rem_nxt;

  logic [TGT_W-1:0]    bc;
  logic [TGT_W-1:0]    target;
  logic [MAGIC_W-1:0]  mask;
  logic [MAGIC_W-1:0]  field;
  logic                busy;
  logic [MLEN_W-1:0]   mbytes;
  logic [ELEN_W-1:0]   ebytes;

  assign mbytes = magic_bytes(cfg.magic_length);
  assign ebytes = ext_bytes(cfg.extension_length);

  always_comb begin
    phase_nxt = phase_r;
    hcnt_nxt  = hcnt_r;
    bc        = {1'b0, bcnt_r};
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    res       = '0;
    busy      = 1'b1;
    target    = BYTE_BITS;
    mask      = '0;
    field     = '0;

    // image start: restart the parse on this very byte
    if (stg_first) begin
      phase_nxt = PH_HEADER;
      hcnt_nxt  = '0;
      rem_nxt   = '0;
      bc        = '0;
      acc_nxt   = '0;
    end

    if (phase_nxt == PH_HEADER) begin
      if (hcnt_nxt < cfg.header_skip) begin
        hcnt_nxt = hcnt_nxt + HDR_W'(1);
        busy     = 1'b0;
      end else begin
        phase_nxt = PH_MAGIC;
        bc        = '0;
        acc_nxt   = '0;
      end
    end

    if (busy && phase_nxt != PH_IDLE) begin
      acc_nxt = {acc_nxt[MAGIC_W-2:0], stg_bit};
      bc      = bc + TGT_W'(1);
      unique case (phase_nxt)
        PH_MAGIC:             target = {mbytes, 3'b000};
        PH_EXT:               target = {1'b0, ebytes, 3'b000};
        PH_EXTLEN, PH_SIZE:   target = WORD_BITS;
        default:              target = BYTE_BITS;
      endcase
      mask  = {MAGIC_W{1'b1}} >> (TGT_W'(MAGIC_W) - target);
      field = acc_nxt & mask;

      if (bc >= target) begin
        bc      = '0;
        acc_nxt = '0;
        unique case (phase_nxt)
          PH_MAGIC: begin
            if (field != (cfg.magic_value & mask)) begin
              phase_nxt  = PH_IDLE;
              res.vld    = 1'b1;
              res.status = ST_MAGIC_ERR;
            end else begin
              phase_nxt = PH_EXTLEN;
            end
          end
          PH_EXTLEN: begin
            if (field != MAGIC_W'(ebytes)) begin
              phase_nxt  = PH_IDLE;
              res.vld    = 1'b1;
              res.status = ST_EXTLEN_ERR;
            end else begin
              phase_nxt = PH_EXT;
            end
          end
          PH_EXT: begin
            if (field != (MAGIC_W'(cfg.extension_value) & mask)) begin
              phase_nxt  = PH_IDLE;
              res.vld    = 1'b1;
              res.status = ST_EXT_ERR;
            end else begin
              phase_nxt = PH_SIZE;
            end
          end
          PH_SIZE: begin
            rem_nxt   = field[SIZE_W-1:0];
            phase_nxt = (field[SIZE_W-1:0] == '0) ? PH_IDLE : PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            rem_nxt    = rem_nxt - SIZE_W'(1);
            res.vld    = 1'b1;
            res.data   = field[7:0];
            res.status = ST_DATA;
            res.last   = (rem_nxt == '0);
            if (rem_nxt == '0) phase_nxt = PH_IDLE;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end

    bcnt_nxt = bc[BCNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hcnt_r  <= '0;
      bcnt_r  <= '0;
      acc_r   <= '0;
      rem_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      hcnt_r  <= hcnt_nxt;
      bcnt_r  <= bcnt_nxt;
      acc_r   <= acc_nxt;
      rem_r   <= rem_nxt;
    end
  end

`ifndef SYNTHESIS
  a_err_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.vld && res.status != ST_DATA |=> phase_r == PH_IDLE)
    else $error("error result did not park the parser");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.vld && res.last |=> phase_r == PH_IDLE && rem_r == '0)
    else $error("last payload byte did not end the frame");

  a_data_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.vld && res.status == ST_DATA |-> phase_r == PH_PAYLOAD && !stg_first)
    else $error("data result outside payload phase");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(phase_r) && $stable(rem_r) && $stable(bcnt_r))
    else $error("parse state moved without a byte");
`endif

endmodule : lsfe_parser
`default_nettype wire

[hdl/lsfe_out_reg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// lsfe_out_reg - result register
// Holds one result until the consumer takes it; reloads in the cycle it
// drains.
// ---------------------------------------------------------------------------
module lsfe_out_reg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire lsfe_pkg::lsfe_res_t res,
  output logic                     out_free,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               out_secret_byte,
  output logic [1:0]               out_status,
  output logic                     out_last_byte
);
  import lsfe_pkg::*;

  logic       vld_r, vld_nxt;
  logic [7:0] data_r;
  logic [1:0] status_r;
  logic       last_r;

  assign out_free = ~vld_r | out_ready;
  assign vld_nxt  = (load & res.vld) | (vld_r & ~out_ready);

  assign out_valid       = vld_r;
  assign out_secret_byte = data_r;
  assign out_status      = status_r;
  assign out_last_byte   = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.vld) begin
      data_r   <= res.data;
      status_r <= res.status;
      last_r   <= res.last;
    end
  end

endmodule : lsfe_out_reg
`default_nettype wire

[hdl/lsb_stego_frame_extractor.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// lsb_stego_frame_extractor - LSB hidden frame extractor, top level
// Skips the image header, gathers the low bit of each image byte into
// hidden bytes, checks magic, extension length and extension, reads the
// payload size and emits the payload bytes or one error status.
// ---------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------
//  in_      | in        | in_valid / in_ready  | pixel_byte, first_of_image
//  out_     | out       | out_valid / out_ready| secret_byte, status, last_byte
//  cfg_     | in        | cfg_wr_en            | cfg_index, cfg_wdata
//
//  One request per cycle sustained while the result register is not stalled;
//  an accepted byte is held in the input register, parsed once the result
//  register is free, and its result, if any, is registered in the result
//  register, which drives out_valid.
//  Reset (rst_n low, synchronous) clears the parse state, the stage and
//  result valid bits and loads the register defaults.
//  A stalled result register holds the staged byte; the input register then
//  drops ready until the result drains.
//
module lsb_stego_frame_extractor (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [7:0]                         in_pixel_byte,
  input  wire logic                               in_first_of_image,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [7:0]                              out_secret_byte,
  output logic [1:0]                              out_status,
  output logic                                    out_last_byte,
  input  wire logic                               cfg_wr_en,
  input  wire logic [lsfe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lsfe_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import lsfe_pkg::*;

  lsfe_cfg_t cfg_r;
  lsfe_res_t res;
  logic      out_free;
  logic      take;
  logic      stg_bit;
  logic      stg_first;

  // Configuration registers: written directly, take effect on the next byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_skip      <= HDR_SKIP_RST;
      cfg_r.magic_value      <= MAGIC_RST;
      cfg_r.magic_length     <= MLEN_RST;
      cfg_r.extension_value  <= EXT_RST;
      cfg_r.extension_length <= ELEN_RST;
    end else if (cfg_wr_en) begin
      unique case (lsfe_cfg_idx_t'(cfg_index))
        CFG_HEADER_SKIP: cfg_r.header_skip      <= cfg_wdata[HDR_W-1:0];
        CFG_MAGIC_VALUE: cfg_r.magic_value      <= cfg_wdata[MAGIC_W-1:0];
        CFG_MAGIC_LEN:   cfg_r.magic_length     <= cfg_wdata[MLEN_W-1:0];
        CFG_EXT_VALUE:   cfg_r.extension_value  <= cfg_wdata[EXT_W-1:0];
        CFG_EXT_LEN:     cfg_r.extension_length <= cfg_wdata[ELEN_W-1:0];
        default:         ; // unmapped index: drop the write
      endcase
    end
  end

  // Input register: one byte staged ahead of the parser
  lsfe_in_stage u_in_stage (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pixel_byte     (in_pixel_byte),
    .in_first_of_image (in_first_of_image),
    .out_free          (out_free),
    .take              (take),
    .stg_bit           (stg_bit),
    .stg_first         (stg_first)
  );

  // Parser: advance the field state whenever the staged byte is taken
  lsfe_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (take),
    .stg_bit   (stg_bit),
    .stg_first (stg_first),
    .cfg       (cfg_r),
    .res       (res)
  );

  // Result register: holds each result until the consumer takes it
  lsfe_out_reg u_out_reg (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (take),
    .res             (res),
    .out_free        (out_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_secret_byte (out_secret_byte),
    .out_status      (out_status),
    .out_last_byte   (out_last_byte)
  );

endmodule : lsb_stego_frame_extractor
`default_nettype wire
